>>> hdl/percpu_priority_ready_queues_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-CPU ready queue unit
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PERCPU_PRIORITY_READY_QUEUES_UNIT_DEFINES_SVH
`define PERCPU_PRIORITY_READY_QUEUES_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PPQ_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication, disabled in reset
`define PPQ_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

>>> hdl/ppq_pkg.sv
// ----------------------------------------------------------------------------
// ppq_pkg
// Types, sizes, command codes and helpers of the per-CPU ready queue unit.
// ----------------------------------------------------------------------------
`default_nettype none
package ppq_pkg;

  localparam int THREADS = 64;
  localparam int CPUS    = 4;
  localparam int PRIOS   = 8;
  localparam int CHANS   = THREADS + PRIOS;
  localparam int QUEUES  = CPUS * CHANS;
  localparam int TW      = $clog2(THREADS);
  localparam int LW      = $clog2(THREADS + 1);
  localparam int QW      = $clog2(QUEUES);
  localparam int CW      = $clog2(CPUS);
  localparam int OW      = $clog2(CPUS + 1);
  localparam int PW      = $clog2(PRIOS);

  localparam logic [2:0] CMD_ENQ  = 3'd0;
  localparam logic [2:0] CMD_DEQ  = 3'd1;
  localparam logic [2:0] CMD_REM  = 3'd2;
  localparam logic [2:0] CMD_RENQ = 3'd3;
  localparam logic [2:0] CMD_RDEQ = 3'd4;
  localparam logic [2:0] CMD_RREM = 3'd5;

  typedef struct packed {
    logic [2:0]        command;
    logic [1:0]        cpu;
    logic [6:0]        channel;
    logic [5:0]        thread_id;
    logic signed [7:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [6:0] result_thread;
    logic       found;
    logic       stolen;
  } rsp_t;

  // decoded item handed to the sequencer
  typedef struct packed {
    logic [2:0]    command;
    logic [CW-1:0] cpu;
    logic [6:0]    channel;
    logic          chan_ok;
    logic [TW-1:0] thread;
    logic [PW-1:0] prio;
  } ctl_req_t;

  typedef struct packed {
    logic          nx_we;
    logic [TW-1:0] nx_wa;
    logic [LW-1:0] nx_wd;
    logic [TW-1:0] nx_ra;
    logic          pv_we;
    logic [TW-1:0] pv_wa;
    logic [LW-1:0] pv_wd;
    logic [TW-1:0] pv_ra;
    logic          pr_we;
    logic [TW-1:0] pr_wa;
    logic [PW-1:0] pr_wd;
    logic [TW-1:0] pr_ra;
    logic          ow_we;
    logic [TW-1:0] ow_wa;
    logic [OW-1:0] ow_wd;
    logic [TW-1:0] ow_ra;
    logic          hd_we;
    logic [QW-1:0] hd_wa;
    logic [LW-1:0] hd_wd;
    logic [QW-1:0] hd_ra;
    logic          tl_we;
    logic [QW-1:0] tl_wa;
    logic [LW-1:0] tl_wd;
    logic [QW-1:0] tl_ra;
  } mem_req_t;

  typedef struct packed {
    logic [LW-1:0] nx_rd;
    logic [LW-1:0] pv_rd;
    logic [PW-1:0] pr_rd;
    logic [OW-1:0] ow_rd;
    logic [LW-1:0] hd_rd;
    logic [LW-1:0] tl_rd;
  } mem_rsp_t;

  function automatic logic [PW-1:0] clamp_prio(input logic signed [7:0] v);
    logic [PW-1:0] r;
    if (v < 8'sd0)
      r = '0;
    else if (v > 8'(PRIOS - 1))
      r = PW'(PRIOS - 1);
    else
      r = v[PW-1:0];
    return r;
  endfunction

  // index of a CPU's first channel
  function automatic logic [QW-1:0] qbase(input logic [CW-1:0] c);
    return QW'(QW'(c) * QW'(CHANS));
  endfunction

  // index of a CPU's ready channel for a priority
  function automatic logic [QW-1:0] rq_index(input logic [CW-1:0] c, input logic [PW-1:0] p);
    return QW'(qbase(c) + QW'(THREADS) + QW'(p));
  endfunction

endpackage
`default_nettype wire

>>> hdl/percpu_priority_ready_queues_unit.sv
// Ready dequeue: tries the local priorities from highest down; if all are empty, it walks
// the priority lists of each other CPU, one link a cycle, to count their load, then pops
// from the most loaded CPU, highest priority first; with nothing to steal it answers empty.
// One item at a time, the next accepted in the cycle after done; the receiver cannot stall.
// Reset: busy during a clearing pass over the queue memories.
// ----------------------------------------------------------------------------
// percpu_priority_ready_queues_unit
// Per-CPU linked thread queues with priority ready queues and work stealing.
// ----------------------------------------------------------------------------
`default_nettype none
module percpu_priority_ready_queues_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire ppq_pkg::req_t request,
  output logic               busy,
  output logic               done,
  output ppq_pkg::rsp_t      result
);

  ppq_pkg::ctl_req_t creq;
  ppq_pkg::mem_req_t mreq;
  ppq_pkg::mem_rsp_t mrsp;
  logic go;

  assign go = start && !busy;

  // decode the item: clamp priority, check channel range
  always_comb begin
    creq.command = request.command;
    creq.cpu     = request.cpu;
    creq.channel = request.channel;
    creq.chan_ok = (request.channel < 7'(ppq_pkg::CHANS));
    creq.thread  = request.thread_id;
    creq.prio    = ppq_pkg::clamp_prio(request.priority_req);
  end

  ppq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .req    (creq),
    .busy   (busy),
    .done   (done),
    .result (result),
    .mreq   (mreq),
    .mrsp   (mrsp)
  );

  ppq_ram #(.W(ppq_pkg::LW), .DEPTH(ppq_pkg::THREADS)) u_next (
    .clk(clk), .we(mreq.nx_we), .waddr(mreq.nx_wa), .wdata(mreq.nx_wd),
    .raddr(mreq.nx_ra), .rdata(mrsp.nx_rd)
  );

  ppq_ram #(.W(ppq_pkg::LW), .DEPTH(ppq_pkg::THREADS)) u_prev (
    .clk(clk), .we(mreq.pv_we), .waddr(mreq.pv_wa), .wdata(mreq.pv_wd),
    .raddr(mreq.pv_ra), .rdata(mrsp.pv_rd)
  );

  ppq_ram #(.W(ppq_pkg::PW), .DEPTH(ppq_pkg::THREADS)) u_prio (
    .clk(clk), .we(mreq.pr_we), .waddr(mreq.pr_wa), .wdata(mreq.pr_wd),
    .raddr(mreq.pr_ra), .rdata(mrsp.pr_rd)
  );

  ppq_ram #(.W(ppq_pkg::OW), .DEPTH(ppq_pkg::THREADS)) u_owner (
    .clk(clk), .we(mreq.ow_we), .waddr(mreq.ow_wa), .wdata(mreq.ow_wd),
    .raddr(mreq.ow_ra), .rdata(mrsp.ow_rd)
  );

  ppq_ram #(.W(ppq_pkg::LW), .DEPTH(ppq_pkg::QUEUES)) u_head (
    .clk(clk), .we(mreq.hd_we), .waddr(mreq.hd_wa), .wdata(mreq.hd_wd),
    .raddr(mreq.hd_ra), .rdata(mrsp.hd_rd)
  );

  ppq_ram #(.W(ppq_pkg::LW), .DEPTH(ppq_pkg::QUEUES)) u_tail (
    .clk(clk), .we(mreq.tl_we), .waddr(mreq.tl_wa), .wdata(mreq.tl_wd),
    .raddr(mreq.tl_ra), .rdata(mrsp.tl_rd)
  );

endmodule
`default_nettype wire

>>> hdl/ppq_ram.sv
// ----------------------------------------------------------------------------
// ppq_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ppq_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we)
      mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/ppq_ctrl.sv
// ----------------------------------------------------------------------------
// ppq_ctrl
// Sequencer for list edits, priority scan and the load-count walk.
// ----------------------------------------------------------------------------
`default_nettype none
module ppq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire ppq_pkg::ctl_req_t req,
  output logic                   busy,
  output logic                   done,
  output ppq_pkg::rsp_t          result,
  output ppq_pkg::mem_req_t      mreq,
  input  wire ppq_pkg::mem_rsp_t mrsp
);

  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_DISP     = 5'd2;
  localparam logic [4:0] S_PUSH_RD  = 5'd3;
  localparam logic [4:0] S_PUSH_EX  = 5'd4;
  localparam logic [4:0] S_PUSH_EX2 = 5'd5;
  localparam logic [4:0] S_POP_RD   = 5'd6;
  localparam logic [4:0] S_POP_A    = 5'd7;
  localparam logic [4:0] S_POP_B    = 5'd8;
  localparam logic [4:0] S_POP_C    = 5'd9;
  localparam logic [4:0] S_UNL_RD   = 5'd10;
  localparam logic [4:0] S_UNL_EX   = 5'd11;
  localparam logic [4:0] S_UNL_FIN  = 5'd12;
  localparam logic [4:0] S_R5_RD    = 5'd13;
  localparam logic [4:0] S_R5_EX    = 5'd14;
  localparam logic [4:0] S_LD_HEAD  = 5'd15;
  localparam logic [4:0] S_LD_WALK  = 5'd16;
  localparam logic [4:0] S_LD_NEXT  = 5'd17;
  localparam logic [4:0] S_RESP     = 5'd18;

  localparam int LDW = $clog2(ppq_pkg::THREADS * ppq_pkg::PRIOS + 1);
  localparam logic [ppq_pkg::LW-1:0] NONE = ppq_pkg::LW'(ppq_pkg::THREADS);
  localparam logic [ppq_pkg::PW-1:0] PTOP = ppq_pkg::PW'(ppq_pkg::PRIOS - 1);
  localparam logic [ppq_pkg::OW-1:0] NOCPU = ppq_pkg::OW'(ppq_pkg::CPUS);

  logic [4:0] state, state_next;
  logic [ppq_pkg::QW-1:0] clr, clr_next;
  ppq_pkg::ctl_req_t r, r_next;
  logic [ppq_pkg::QW-1:0] q, q_next;
  logic [ppq_pkg::LW-1:0] first, first_next;
  logic [ppq_pkg::LW-1:0] res, res_next;
  logic stl, stl_next;
  logic rdy, rdy_next;
  logic steal, steal_next;
  logic own_clr, own_clr_next;
  logic [ppq_pkg::CW-1:0] rc, rc_next;
  logic [ppq_pkg::PW-1:0] p, p_next;
  logic [ppq_pkg::OW-1:0] d, d_next;
  logic [ppq_pkg::PW-1:0] lp, lp_next;
  logic [LDW-1:0] total, total_next;
  logic [ppq_pkg::LW-1:0] steps, steps_next;
  logic from_head, from_head_next;
  logic [ppq_pkg::OW-1:0] best, best_next;
  logic [LDW-1:0] top_load, top_load_next;

  logic [ppq_pkg::LW-1:0] cur;
  logic [ppq_pkg::OW-1:0] nd, b_new;
  logic [LDW-1:0] bl_new;

  assign cur = from_head ? mrsp.hd_rd : mrsp.nx_rd;

  always_comb begin
    state_next     = state;
    clr_next       = clr;
    r_next         = r;
    q_next         = q;
    first_next     = first;
    res_next       = res;
    stl_next       = stl;
    rdy_next       = rdy;
    steal_next     = steal;
    own_clr_next   = own_clr;
    rc_next        = rc;
    p_next         = p;
    d_next         = d;
    lp_next        = lp;
    total_next     = total;
    steps_next     = steps;
    from_head_next = from_head;
    best_next      = best;
    top_load_next  = top_load;
    nd             = '0;
    b_new          = best;
    bl_new         = top_load;

    mreq       = '0;
    mreq.nx_ra = r.thread;
    mreq.pv_ra = r.thread;
    mreq.pr_ra = r.thread;
    mreq.ow_ra = r.thread;
    mreq.hd_ra = q;
    mreq.tl_ra = q;

    unique case (state)
      S_CLEAR: begin
        mreq.hd_we = 1'b1;
        mreq.hd_wa = clr;
        mreq.hd_wd = NONE;
        mreq.tl_we = 1'b1;
        mreq.tl_wa = clr;
        mreq.tl_wd = NONE;
        if (clr < ppq_pkg::QW'(ppq_pkg::THREADS)) begin
          mreq.nx_we = 1'b1;
          mreq.nx_wa = clr[ppq_pkg::TW-1:0];
          mreq.nx_wd = NONE;
          mreq.pv_we = 1'b1;
          mreq.pv_wa = clr[ppq_pkg::TW-1:0];
          mreq.pv_wd = NONE;
          mreq.pr_we = 1'b1;
          mreq.pr_wa = clr[ppq_pkg::TW-1:0];
          mreq.pr_wd = '0;
          mreq.ow_we = 1'b1;
          mreq.ow_wa = clr[ppq_pkg::TW-1:0];
          mreq.ow_wd = NOCPU;
        end
        if (clr == ppq_pkg::QW'(ppq_pkg::QUEUES - 1))
          state_next = S_IDLE;
        else
          clr_next = ppq_pkg::QW'(clr + 1'b1);
      end
      S_IDLE: begin
        if (go) begin
          r_next     = req;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        res_next     = NONE;
        stl_next     = 1'b0;
        rdy_next     = 1'b0;
        steal_next   = 1'b0;
        own_clr_next = 1'b0;
        q_next       = ppq_pkg::QW'(ppq_pkg::qbase(r.cpu) + ppq_pkg::QW'(r.channel));
        case (r.command)
          ppq_pkg::CMD_ENQ: state_next = r.chan_ok ? S_PUSH_RD : S_RESP;
          ppq_pkg::CMD_DEQ: state_next = r.chan_ok ? S_POP_RD : S_RESP;
          ppq_pkg::CMD_REM: state_next = r.chan_ok ? S_UNL_RD : S_RESP;
          ppq_pkg::CMD_RENQ: begin
            mreq.pr_we = 1'b1;
            mreq.pr_wa = r.thread;
            mreq.pr_wd = r.prio;
            mreq.ow_we = 1'b1;
            mreq.ow_wa = r.thread;
            mreq.ow_wd = ppq_pkg::OW'(r.cpu);
            q_next     = ppq_pkg::rq_index(r.cpu, r.prio);
            state_next = S_PUSH_RD;
          end
          ppq_pkg::CMD_RDEQ: begin
            rdy_next   = 1'b1;
            rc_next    = r.cpu;
            p_next     = PTOP;
            q_next     = ppq_pkg::rq_index(r.cpu, PTOP);
            state_next = S_POP_RD;
          end
          ppq_pkg::CMD_RREM: state_next = S_R5_RD;
          default: state_next = S_RESP;
        endcase
      end
      S_PUSH_RD: state_next = S_PUSH_EX;
      S_PUSH_EX: begin
        mreq.tl_we = 1'b1;
        mreq.tl_wa = q;
        mreq.tl_wd = ppq_pkg::LW'(r.thread);
        mreq.pv_we = 1'b1;
        mreq.pv_wa = r.thread;
        if (mrsp.tl_rd >= NONE) begin
          mreq.pv_wd = NONE;
          mreq.hd_we = 1'b1;
          mreq.hd_wa = q;
          mreq.hd_wd = ppq_pkg::LW'(r.thread);
        end else begin
          mreq.pv_wd = mrsp.tl_rd;
          mreq.nx_we = 1'b1;
          mreq.nx_wa = mrsp.tl_rd[ppq_pkg::TW-1:0];
          mreq.nx_wd = ppq_pkg::LW'(r.thread);
        end
        state_next = S_PUSH_EX2;
      end
      S_PUSH_EX2: begin
        mreq.nx_we = 1'b1;
        mreq.nx_wa = r.thread;
        mreq.nx_wd = NONE;
        state_next = S_RESP;
      end
      S_POP_RD: state_next = S_POP_A;
      S_POP_A: begin
        first_next = mrsp.hd_rd;
        mreq.nx_ra = mrsp.hd_rd[ppq_pkg::TW-1:0];
        if (mrsp.hd_rd < NONE) begin
          state_next = S_POP_B;
        end else if (rdy && p != '0) begin
          // try the next lower priority
          p_next     = ppq_pkg::PW'(p - 1'b1);
          q_next     = ppq_pkg::QW'(q - 1'b1);
          state_next = S_POP_RD;
        end else if (rdy && !steal) begin
          d_next         = (rc == '0) ? ppq_pkg::OW'(1) : '0;
          lp_next        = '0;
          total_next     = '0;
          best_next      = NOCPU;
          top_load_next  = '0;
          state_next     = S_LD_HEAD;
        end else begin
          state_next = S_RESP;
        end
      end
      S_POP_B: begin
        mreq.hd_we = 1'b1;
        mreq.hd_wa = q;
        if (mrsp.nx_rd >= NONE) begin
          mreq.hd_wd = NONE;
          mreq.tl_we = 1'b1;
          mreq.tl_wa = q;
          mreq.tl_wd = NONE;
        end else begin
          mreq.hd_wd = mrsp.nx_rd;
          mreq.pv_we = 1'b1;
          mreq.pv_wa = mrsp.nx_rd[ppq_pkg::TW-1:0];
          mreq.pv_wd = NONE;
        end
        state_next = S_POP_C;
      end
      S_POP_C: begin
        mreq.pv_we = 1'b1;
        mreq.pv_wa = first[ppq_pkg::TW-1:0];
        mreq.pv_wd = NONE;
        mreq.nx_we = 1'b1;
        mreq.nx_wa = first[ppq_pkg::TW-1:0];
        mreq.nx_wd = NONE;
        if (rdy) begin
          mreq.ow_we = 1'b1;
          mreq.ow_wa = first[ppq_pkg::TW-1:0];
          mreq.ow_wd = NOCPU;
        end
        res_next   = first;
        stl_next   = steal;
        state_next = S_RESP;
      end
      S_UNL_RD: state_next = S_UNL_EX;
      S_UNL_EX: begin
        if (mrsp.pv_rd >= NONE) begin
          mreq.hd_we = 1'b1;
          mreq.hd_wa = q;
          if (mrsp.nx_rd >= NONE) begin
            mreq.hd_wd = NONE;
            mreq.tl_we = 1'b1;
            mreq.tl_wa = q;
            mreq.tl_wd = NONE;
          end else begin
            mreq.hd_wd = mrsp.nx_rd;
            mreq.pv_we = 1'b1;
            mreq.pv_wa = mrsp.nx_rd[ppq_pkg::TW-1:0];
            mreq.pv_wd = NONE;
          end
        end else begin
          mreq.nx_we = 1'b1;
          mreq.nx_wa = mrsp.pv_rd[ppq_pkg::TW-1:0];
          mreq.nx_wd = mrsp.nx_rd;
          if (mrsp.nx_rd >= NONE) begin
            mreq.tl_we = 1'b1;
            mreq.tl_wa = q;
            mreq.tl_wd = mrsp.pv_rd;
          end else begin
            mreq.pv_we = 1'b1;
            mreq.pv_wa = mrsp.nx_rd[ppq_pkg::TW-1:0];
            mreq.pv_wd = mrsp.pv_rd;
          end
        end
        state_next = S_UNL_FIN;
      end
      S_UNL_FIN: begin
        mreq.pv_we = 1'b1;
        mreq.pv_wa = r.thread;
        mreq.pv_wd = NONE;
        mreq.nx_we = 1'b1;
        mreq.nx_wa = r.thread;
        mreq.nx_wd = NONE;
        if (own_clr) begin
          mreq.ow_we = 1'b1;
          mreq.ow_wa = r.thread;
          mreq.ow_wd = NOCPU;
        end
        state_next = S_RESP;
      end
      S_R5_RD: state_next = S_R5_EX;
      S_R5_EX: begin
        if (mrsp.ow_rd < NOCPU) begin
          own_clr_next = 1'b1;
          q_next       = ppq_pkg::rq_index(mrsp.ow_rd[ppq_pkg::CW-1:0], mrsp.pr_rd);
          state_next   = S_UNL_RD;
        end else begin
          state_next = S_RESP;
        end
      end
      S_LD_HEAD: begin
        mreq.hd_ra     = ppq_pkg::rq_index(d[ppq_pkg::CW-1:0], lp);
        steps_next     = '0;
        from_head_next = 1'b1;
        state_next     = S_LD_WALK;
      end
      S_LD_WALK: begin
        mreq.nx_ra = cur[ppq_pkg::TW-1:0];
        // follow one link a cycle, bounded by the thread count
        if (cur < NONE && steps < NONE) begin
          total_next     = LDW'(total + 1'b1);
          steps_next     = ppq_pkg::LW'(steps + 1'b1);
          from_head_next = 1'b0;
        end else begin
          state_next = S_LD_NEXT;
        end
      end
      S_LD_NEXT: begin
        if (lp != PTOP) begin
          lp_next    = ppq_pkg::PW'(lp + 1'b1);
          state_next = S_LD_HEAD;
        end else begin
          if (total > top_load) begin
            b_new  = d;
            bl_new = total;
          end
          best_next      = b_new;
          top_load_next  = bl_new;
          nd = ppq_pkg::OW'(d + 1'b1);
          if (nd < NOCPU && nd[ppq_pkg::CW-1:0] == rc)
            nd = ppq_pkg::OW'(nd + 1'b1);
          if (nd >= NOCPU) begin
            if (bl_new != '0) begin
              steal_next = 1'b1;
              rc_next    = b_new[ppq_pkg::CW-1:0];
              p_next     = PTOP;
              q_next     = ppq_pkg::rq_index(b_new[ppq_pkg::CW-1:0], PTOP);
              state_next = S_POP_RD;
            end else begin
              state_next = S_RESP;
            end
          end else begin
            d_next     = nd;
            lp_next    = '0;
            total_next = '0;
            state_next = S_LD_HEAD;
          end
        end
      end
      S_RESP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
    r         <= r_next;
    q         <= q_next;
    first     <= first_next;
    res       <= res_next;
    stl       <= stl_next;
    rdy       <= rdy_next;
    steal     <= steal_next;
    own_clr   <= own_clr_next;
    rc        <= rc_next;
    p         <= p_next;
    d         <= d_next;
    lp        <= lp_next;
    total     <= total_next;
    steps     <= steps_next;
    from_head <= from_head_next;
    best      <= best_next;
    top_load  <= top_load_next;
  end

  assign busy                 = (state != S_IDLE);
  assign done                 = (state == S_RESP);
  assign result.result_thread = res;
  assign result.found         = (res < NONE);
  assign result.stolen        = stl;

endmodule
`default_nettype wire

>>> hdl/ppq_check.sv
// ----------------------------------------------------------------------------
// ppq_check
// Port-level checks of the per-CPU ready queue unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "percpu_priority_ready_queues_unit_defines.svh"
module ppq_check (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done,
  input wire ppq_pkg::rsp_t result
);

  `PPQ_ASSERT_IMP(a_done_busy, clk, rst, done, busy, "done outside a busy item")
  `PPQ_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "not busy after accept")
  `PPQ_ASSERT_IMP(a_none_thread, clk, rst, done && !result.found, result.result_thread == 7'(ppq_pkg::THREADS), "empty result carries a thread")
  `PPQ_ASSERT_IMP(a_stolen_found, clk, rst, done && result.stolen, result.found, "steal without a thread")

endmodule

bind percpu_priority_ready_queues_unit ppq_check u_check (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire

>>> dv/percpu_priority_ready_queues_unit_checker.sv
// ----------------------------------------------------------------------------
// percpu_priority_ready_queues_unit_checker
// Watches the command and result channels of the ready queue unit, keeps its
// own copy of the linked lists and predicts every result in order.
// ----------------------------------------------------------------------------
`default_nettype none
module percpu_priority_ready_queues_unit_checker
  import ppq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic busy,
  input  wire req_t request,
  input  wire logic done,
  input  wire rsp_t result,
  output int        fails,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [6:0] NIL = 7'(THREADS);

  logic [6:0] nxt [THREADS];
  logic [6:0] prv [THREADS];
  logic [2:0] tprio [THREADS];
  logic [2:0] owner [THREADS];
  logic [6:0] qhead [QUEUES];
  logic [6:0] qtail [QUEUES];
  rsp_t       expected_rsp [$];

  function automatic void clear_lists();
    for (int i = 0; i < THREADS; i++) begin
      nxt[i] = NIL; prv[i] = NIL; tprio[i] = '0; owner[i] = 3'(CPUS);
    end
    for (int i = 0; i < QUEUES; i++) begin
      qhead[i] = NIL; qtail[i] = NIL;
    end
  endfunction

  function automatic void push_tail(int q, int t);
    int last;
    last = qtail[q];
    if (last >= THREADS) begin
      qhead[q] = 7'(t);
    end else begin
      nxt[last] = 7'(t);
    end
    prv[t] = (last >= THREADS) ? NIL : 7'(last);
    nxt[t] = NIL;
    qtail[q] = 7'(t);
  endfunction

  function automatic int pop_head(int q);
    int first;
    int after;
    first = qhead[q];
    if (first >= THREADS) return THREADS;
    after = nxt[first];
    if (after >= THREADS) begin
      qhead[q] = NIL; qtail[q] = NIL;
    end else begin
      prv[after] = NIL; qhead[q] = 7'(after);
    end
    prv[first] = NIL; nxt[first] = NIL;
    return first;
  endfunction

  function automatic void unlink(int q, int t);
    int p;
    int n;
    p = prv[t];
    n = nxt[t];
    if (p >= THREADS) begin
      if (n >= THREADS) begin
        qhead[q] = NIL; qtail[q] = NIL;
      end else begin
        prv[n] = NIL; qhead[q] = 7'(n);
      end
    end else begin
      if (n >= THREADS) begin
        nxt[p] = NIL; qtail[q] = 7'(p);
      end else begin
        nxt[p] = 7'(n); prv[n] = 7'(p);
      end
    end
    prv[t] = NIL; nxt[t] = NIL;
  endfunction

  // highest priority first
  function automatic int pop_ready(int c);
    int t;
    for (int p = PRIOS - 1; p >= 0; p--) begin
      t = pop_head(c * CHANS + THREADS + p);
      if (t < THREADS) begin
        owner[t] = 3'(CPUS);
        return t;
      end
    end
    return THREADS;
  endfunction

  // walk of each list is bounded, lists may be corrupt
  function automatic int ready_count(int c);
    int total;
    int t;
    int steps;
    total = 0;
    for (int p = 0; p < PRIOS; p++) begin
      t = qhead[c * CHANS + THREADS + p];
      steps = 0;
      while (t < THREADS && steps < THREADS) begin
        total++; steps++; t = nxt[t];
      end
    end
    return total;
  endfunction

  function automatic rsp_t schedule(req_t r);
    rsp_t o;
    int c, ch, t, pr, res, best, top_load, ld, q;
    logic stl;
    c = r.cpu; ch = r.channel; t = r.thread_id;
    pr = r.priority_req;
    if (pr > PRIOS - 1) pr = PRIOS - 1;
    if (pr < 0) pr = 0;
    res = THREADS;
    stl = 1'b0;
    if (c < CPUS) begin
      case (r.command)
        CMD_ENQ: if (ch < CHANS) push_tail(c * CHANS + ch, t);
        CMD_DEQ: if (ch < CHANS) res = pop_head(c * CHANS + ch);
        CMD_REM: if (ch < CHANS) unlink(c * CHANS + ch, t);
        CMD_RENQ: begin
          tprio[t] = 3'(pr);
          owner[t] = 3'(c);
          push_tail(c * CHANS + THREADS + pr, t);
        end
        CMD_RDEQ: begin
          res = pop_ready(c);
          if (res >= THREADS) begin
            best = CPUS;
            top_load = 0;
            for (int d = 0; d < CPUS; d++) begin
              if (d != c) begin
                ld = ready_count(d);
                if (ld > top_load) begin
                  top_load = ld; best = d;
                end
              end
            end
            if (best < CPUS) begin
              res = pop_ready(best);
              stl = (res < THREADS);
            end
          end
        end
        CMD_RREM: if (owner[t] < CPUS) begin
          q = owner[t] * CHANS + THREADS + tprio[t];
          unlink(q, t);
          owner[t] = 3'(CPUS);
        end
        default: ;
      endcase
    end
    o.result_thread = 7'(res);
    o.found = (res < THREADS);
    o.stolen = stl;
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
    clear_lists();
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      clear_lists();
      expected_rsp.delete();
    end else begin
      if (done) begin
        if (expected_rsp.size() == 0) begin
          report("unexpected item, thread", result.result_thread, -1);
        end else begin
          want = expected_rsp.pop_front();
          if (result.result_thread !== want.result_thread)
            report("result_thread", result.result_thread, want.result_thread);
          if (result.found !== want.found) report("found", result.found, want.found);
          if (result.stolen !== want.stolen) report("stolen", result.stolen, want.stolen);
        end
      end
      if (start && !busy) expected_rsp.push_back(schedule(request));
    end
    pending = expected_rsp.size();
  end

endmodule
`default_nettype wire

>>> dv/percpu_priority_ready_queues_unit_test.sv
// ----------------------------------------------------------------------------
// percpu_priority_ready_queues_unit_test
// Drives directed and random scheduler commands with random gaps into the
// ready queue unit; the checker beside it predicts and compares each item.
// ----------------------------------------------------------------------------
`default_nettype none
module percpu_priority_ready_queues_unit_test;
  import ppq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;
  int   fails;
  int   pending;

  // where the stimulus believes each thread is linked
  bit         linked [THREADS];
  logic [1:0] where_cpu [THREADS];
  logic [6:0] where_chan [THREADS];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  percpu_priority_ready_queues_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  percpu_priority_ready_queues_unit_checker i_checker (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result),
    .fails  (fails),
    .pending(pending)
  );

  // release threads that come back out of a queue
  always @(posedge clk) begin
    if (!rst && done && result.found) linked[result.result_thread[5:0]] = 1'b0;
  end

  function automatic req_t cmd(logic [2:0] op, int c, int ch, int t, int pr);
    req_t r;
    r.command = op;
    r.cpu = 2'(c);
    r.channel = 7'(ch);
    r.thread_id = 6'(t);
    r.priority_req = 8'(pr);
    return r;
  endfunction

  task automatic issue(req_t r);
    int gap;
    int pr;
    gap = $urandom_range(0, 15);
    if (($urandom_range(0, 3)) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    if (r.command == CMD_ENQ || r.command == CMD_RENQ) begin
      pr = r.priority_req;
      if (pr < 0) pr = 0;
      if (pr > PRIOS - 1) pr = PRIOS - 1;
      linked[r.thread_id] = 1'b1;
      where_cpu[r.thread_id] = r.cpu;
      where_chan[r.thread_id] = (r.command == CMD_RENQ) ? 7'(THREADS + pr) : r.channel;
    end else if (r.command == CMD_REM || r.command == CMD_RREM) begin
      linked[r.thread_id] = 1'b0;
    end
  endtask

  function automatic int pick_thread(bit want_linked);
    int s;
    s = $urandom_range(0, THREADS - 1);
    for (int i = 0; i < THREADS; i++)
      if (linked[(s + i) % THREADS] == want_linked) return (s + i) % THREADS;
    return -1;
  endfunction

  task automatic random_item();
    int sel, t;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      t = pick_thread(1'b0);
      if (t < 0) issue(cmd(CMD_RDEQ, $urandom_range(0, 3), 0, 0, 0));
      else issue(cmd(CMD_RENQ, $urandom_range(0, 3), $urandom_range(0, 127), t,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 10) - 2));
    end else if (sel < 50) begin
      issue(cmd(CMD_RDEQ, $urandom_range(0, 3), $urandom_range(0, 127),
                $urandom_range(0, 63), $urandom_range(0, 255)));
    end else if (sel < 58) begin
      t = pick_thread(1'b1);
      if (t < 0 || where_chan[t] < THREADS) t = $urandom_range(0, 63);
      issue(cmd(CMD_RREM, $urandom_range(0, 3), 0, t, 0));
    end else if (sel < 70) begin
      t = pick_thread(1'b0);
      if (t >= 0) issue(cmd(CMD_ENQ, $urandom_range(0, 3), $urandom_range(0, 5), t, 0));
      else issue(cmd(CMD_DEQ, $urandom_range(0, 3), $urandom_range(0, 5), 0, 0));
    end else if (sel < 80) begin
      issue(cmd(CMD_DEQ, $urandom_range(0, 3), $urandom_range(0, 5), 0, 0));
    end else if (sel < 90) begin
      t = pick_thread(1'b1);
      if (t >= 0 && where_chan[t] < THREADS)
        issue(cmd(CMD_REM, where_cpu[t], where_chan[t], t, 0));
      else
        issue(cmd(CMD_DEQ, $urandom_range(0, 3), $urandom_range(0, 5), 0, 0));
    end else begin
      issue(req_t'($bits(req_t)'($urandom())));
    end
  endtask

  initial begin
    for (int i = 0; i < THREADS; i++) linked[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every command, empty and steal paths
    issue(cmd(CMD_DEQ, 0, 0, 0, 0));
    issue(cmd(CMD_RDEQ, 3, 0, 0, 0));
    issue(cmd(CMD_ENQ, 0, 0, 0, 0));
    issue(cmd(CMD_ENQ, 0, 0, 63, 0));
    issue(cmd(CMD_ENQ, 3, 71, 5, 0));
    issue(cmd(CMD_ENQ, 1, 72, 6, 0));
    issue(cmd(CMD_ENQ, 1, 127, 7, 0));
    issue(cmd(CMD_REM, 0, 0, 0, 0));
    issue(cmd(CMD_DEQ, 0, 0, 0, 0));
    issue(cmd(CMD_DEQ, 3, 71, 0, 0));
    issue(cmd(CMD_DEQ, 2, 127, 0, 0));
    issue(cmd(CMD_RENQ, 1, 0, 10, -128));
    issue(cmd(CMD_RENQ, 1, 0, 11, 127));
    issue(cmd(CMD_RENQ, 2, 0, 12, 7));
    issue(cmd(CMD_RENQ, 2, 0, 13, 8));
    issue(cmd(CMD_RENQ, 2, 0, 14, -1));
    issue(cmd(CMD_RREM, 0, 0, 20, 0));
    issue(cmd(CMD_RREM, 2, 0, 13, 0));
    issue(cmd(CMD_RDEQ, 0, 0, 0, 0));
    issue(cmd(CMD_RDEQ, 1, 0, 0, 0));
    issue(cmd(CMD_RDEQ, 1, 0, 0, 0));
    issue(cmd(CMD_RDEQ, 3, 0, 0, 0));
    issue(cmd(3'd6, 0, 0, 1, 0));
    issue(cmd(3'd7, 3, 127, 63, -128));

    for (int n = 0; n < 1300; n++) begin
      random_item();
      if (n == 650) begin
        // hold off until the checker has seen the last item through
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
